/* design/compact_size_varint_codec_assert.svh */
// assertion macros for the compact size varint codec
`ifndef COMPACT_SIZE_VARINT_CODEC_ASSERT_SVH
`define COMPACT_SIZE_VARINT_CODEC_ASSERT_SVH

`ifndef ASSERT_OFF
`define CSZV_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
`define CSZV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define CSZV_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define CSZV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* design/cszv_pkg.sv */
// shared types and constants for the compact size varint codec
package cszv_pkg;

	localparam int SIZE_WIDTH_DEF = 32;
	localparam int VALUE_W = 64;
	localparam int SIZE_FIELD_W = 32;

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	localparam logic [7:0] PFX_16 = 8'hfd;
	localparam logic [7:0] PFX_32 = 8'hfe;
	localparam logic [7:0] PFX_64 = 8'hff;
	localparam logic [7:0] MAX_SHORT = 8'd252;

	localparam logic [3:0] EXTRA_NONE = 4'd0;
	localparam logic [3:0] EXTRA_16 = 4'd2;
	localparam logic [3:0] EXTRA_32 = 4'd4;
	localparam logic [3:0] EXTRA_64 = 4'd8;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_VALUE = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] out_byte;
		logic [VALUE_W-1:0] decoded_value;
		logic [3:0] extra_bytes;
		logic [SIZE_FIELD_W-1:0] expected_after;
		logic last;
	} result_t;

	typedef struct packed {
		logic commit;
		logic abandon;
	} dec_ctl_t;

endpackage

/* design/compact_size_varint_codec.sv */
// Compact size varint codec. Decode items (one payload byte each) are taken one per cycle
// unless their result waits on a full output register; a prefix byte gives no result and the
// closing byte of a code gives the value. An encode item stays in the input stage while its
// 1, 3, 5 or 9 bytes (for values up to 252, 65535, 4294967295 or above) leave one per cycle
// through the output register while m_tready allows. The input register and the result register
// decouple the two sides, so a new item is accepted while a finished result still waits on m_tready.
module compact_size_varint_codec
	import cszv_pkg::*;
#(
	parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// value, in_byte, expected_before, payload_size
	input  logic [135:0] s_tdata,
	// op
	input  logic [0:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// out_byte, decoded_value, extra_bytes, expected_after, zero pad
	output logic [111:0] m_tdata,
	// kind
	output logic [1:0] m_tuser,
	output logic m_tlast
);

	`include "compact_size_varint_codec_assert.svh"

	logic valid_s1;
	logic op_s1;
	logic [VALUE_W-1:0] value_s1;
	logic [7:0] byte_s1;
	logic [SIZE_FIELD_W-1:0] exp_s1;
	logic [SIZE_FIELD_W-1:0] pay_s1;
	logic [3:0] enc_idx_q;

	logic m_valid_q;
	result_t m_res_q;

	result_t enc_res;
	result_t dec_res;
	result_t res;
	logic dec_has;
	logic has_res;
	logic load_out;
	logic emit;
	logic s1_done;
	dec_ctl_t dec_ctl;

	cszv_enc u_enc (
		.value(value_s1),
		.idx(enc_idx_q),
		.res(enc_res)
	);

	cszv_dec #(
		.SIZE_WIDTH(SIZE_WIDTH)
	) u_dec (
		.clk(clk),
		.arst_n(arst_n),
		.in_byte(byte_s1),
		.expected_before(exp_s1),
		.payload_size(pay_s1),
		.ctl(dec_ctl),
		.has_result(dec_has),
		.res(dec_res)
	);

	always_comb begin
		res = (op_s1 == OP_DECODE) ? dec_res : enc_res;
		has_res = (op_s1 == OP_DECODE) ? dec_has : 1'b1;
		load_out = !m_valid_q || m_tready;
		emit = valid_s1 && has_res && load_out;
		s1_done = valid_s1 && (!has_res || (load_out && res.last));
		s_tready = !valid_s1 || s1_done;
		dec_ctl.commit = s1_done && (op_s1 == OP_DECODE);
		// an encode item drops any unfinished decode
		dec_ctl.abandon = s1_done && (op_s1 == OP_ENCODE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			enc_idx_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (s1_done) begin
				enc_idx_q <= '0;
			end else if (emit) begin
				enc_idx_q <= enc_idx_q + 4'd1;
			end
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1 <= s_tuser[0];
			value_s1 <= s_tdata[63:0];
			byte_s1 <= s_tdata[71:64];
			exp_s1 <= s_tdata[103:72];
			pay_s1 <= s_tdata[135:104];
		end
		if (emit) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {4'b0000, m_res_q.expected_after, m_res_q.extra_bytes,
		m_res_q.decoded_value, m_res_q.out_byte};
	assign m_tuser = m_res_q.kind;
	assign m_tlast = m_res_q.last;

	`CSZV_ASSERT_SAME(a_enc_idx_bound, clk, arst_n, valid_s1 && (op_s1 == OP_ENCODE), enc_idx_q <= enc_res.extra_bytes)
	`CSZV_ASSERT_SAME(a_dec_single, clk, arst_n, m_tvalid && (m_tuser != KIND_BYTE), m_tlast)
	`CSZV_ASSERT_SAME(a_err_no_value, clk, arst_n, m_tvalid && (m_tuser == KIND_ERROR), (m_tdata[71:8] == '0) && (m_tdata[107:76] == '0))
	`CSZV_ASSERT_NEXT(a_enc_hold, clk, arst_n, valid_s1 && (op_s1 == OP_ENCODE) && !s1_done, valid_s1 && (op_s1 == OP_ENCODE))

endmodule

/* design/cszv_enc.sv */
// encoder byte selector: picks the byte at a given position of the encoded size
module cszv_enc
	import cszv_pkg::*;
(
	input  logic [VALUE_W-1:0] value,
	input  logic [3:0] idx,
	output result_t res
);

	logic short_code;
	logic [7:0] prefix;
	logic [3:0] extra;
	logic [2:0] sel;

	always_comb begin
		short_code = (value[VALUE_W-1:8] == '0) && (value[7:0] <= MAX_SHORT);
		if (value[VALUE_W-1:16] == '0) begin
			prefix = PFX_16;
			extra = EXTRA_16;
		end else if (value[VALUE_W-1:32] == '0) begin
			prefix = PFX_32;
			extra = EXTRA_32;
		end else begin
			prefix = PFX_64;
			extra = EXTRA_64;
		end
		if (short_code) begin
			extra = EXTRA_NONE;
		end
		sel = 3'(idx - 4'd1);

		res = '0;
		res.kind = KIND_BYTE;
		res.extra_bytes = extra;
		if (idx == 4'd0) begin
			res.out_byte = short_code ? value[7:0] : prefix;
		end else begin
			res.out_byte = value[{sel, 3'b000} +: 8];
		end
		res.last = short_code || (idx == extra);
	end

endmodule

/* design/cszv_dec.sv */
// decoder: prefix check, little-endian byte collection and decoder state
module cszv_dec
	import cszv_pkg::*;
#(
	parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] in_byte,
	input  logic [SIZE_FIELD_W-1:0] expected_before,
	input  logic [SIZE_FIELD_W-1:0] payload_size,
	input  dec_ctl_t ctl,
	output logic has_result,
	output result_t res
);

	localparam int SW = (SIZE_WIDTH < SIZE_FIELD_W) ? SIZE_WIDTH : SIZE_FIELD_W;

	logic [3:0] rem_q;
	logic [2:0] col_q;
	logic [VALUE_W-1:0] acc_q;
	logic [3:0] pend_extra_q;
	logic [SIZE_FIELD_W-1:0] pend_exp_q;

	logic busy;
	logic start;
	logic [VALUE_W-1:0] acc_ins;
	logic [3:0] extra;
	logic [SW-1:0] exp_m;
	logic [SW-1:0] pay_m;
	logic [SIZE_FIELD_W:0] sum;
	logic too_big;

	always_comb begin
		busy = (rem_q != 4'd0);
		exp_m = expected_before[SW-1:0];
		pay_m = payload_size[SW-1:0];
		acc_ins = acc_q;
		acc_ins[{col_q, 3'b000} +: 8] = in_byte;
		unique case (in_byte)
			PFX_64: extra = EXTRA_64;
			PFX_32: extra = EXTRA_32;
			PFX_16: extra = EXTRA_16;
			default: extra = EXTRA_NONE;
		endcase
		// expected + extra > payload covers both halves of the size check
		sum = (SIZE_FIELD_W + 1)'(exp_m) + (SIZE_FIELD_W + 1)'(extra);
		too_big = sum > (SIZE_FIELD_W + 1)'(pay_m);
		start = 1'b0;

		res = '0;
		res.kind = KIND_VALUE;
		res.last = 1'b1;
		has_result = 1'b1;
		if (busy) begin
			has_result = (rem_q == 4'd1);
			res.decoded_value = acc_ins;
			res.extra_bytes = pend_extra_q;
			res.expected_after = pend_exp_q;
		end else if (in_byte == 8'd0) begin
			res.expected_after = SIZE_FIELD_W'(exp_m);
		end else if (too_big) begin
			res.kind = KIND_ERROR;
			res.extra_bytes = extra;
		end else if (extra == EXTRA_NONE) begin
			res.decoded_value = VALUE_W'(in_byte);
			res.expected_after = sum[SIZE_FIELD_W-1:0];
		end else begin
			has_result = 1'b0;
			start = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			col_q <= '0;
		end else if (ctl.abandon) begin
			rem_q <= '0;
			col_q <= '0;
		end else if (ctl.commit) begin
			if (busy) begin
				rem_q <= rem_q - 4'd1;
				col_q <= (rem_q == 4'd1) ? 3'd0 : col_q + 3'd1;
			end else if (start) begin
				rem_q <= extra;
				col_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit && busy) begin
			acc_q <= acc_ins;
		end else if (ctl.commit && start) begin
			acc_q <= '0;
			pend_extra_q <= extra;
			pend_exp_q <= sum[SIZE_FIELD_W-1:0];
		end
	end

endmodule
